// File: hdl/sdt2i_pkg.sv
// Package for the strict decimal text to int64 parser.
// Holds the beat payload types, the parse phase codes and the character constants.
// No dependencies.
package sdt2i_pkg;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;

  // Largest magnitude that can still be multiplied by ten without overflow.
  localparam logic [63:0] MagDiv10Limit = 64'h1999_9999_9999_9999;
  localparam logic [63:0] PosLimit      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegLimit      = 64'h8000_0000_0000_0000;

  typedef enum logic [4:0] {
    PhStart  = 5'b00001,
    PhMinus  = 5'b00010,
    PhDigits = 5'b00100,
    PhZero   = 5'b01000,
    PhReject = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
    logic       empty_string;
  } in_beat_t;

  typedef struct packed {
    logic               parse_ok;
    logic signed [63:0] parsed_value;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] magnitude;
    logic        minus_seen;
    phase_e      phase;
  } parse_state_t;

endpackage

// File: hdl/sdt2i_digit_step.sv
// Next-state and result logic of the parser for one character beat.
// Depends on sdt2i_pkg for the state, payload types and character constants.
module sdt2i_digit_step
  import sdt2i_pkg::*;
(
  input  parse_state_t state_i,
  input  in_beat_t     beat_i,
  output parse_state_t state_o,
  output out_beat_t    result_o
);

  logic         is_digit;
  logic [7:0]   char_off;
  logic [3:0]   digit;
  logic [63:0]  times_ten;
  logic [64:0]  sum_wide;
  parse_state_t after_byte;

  assign is_digit  = beat_i.char_byte inside {[CharZero:CharNine]};
  assign char_off  = beat_i.char_byte - CharZero;
  assign digit     = is_digit ? char_off[3:0] : 4'd0;
  // Only used when the magnitude is at or below the divide-by-ten limit, so no bits are lost.
  assign times_ten = {state_i.magnitude[60:0], 3'b000} + {state_i.magnitude[62:0], 1'b0};
  assign sum_wide  = {1'b0, times_ten} + {61'd0, digit};

  always_comb begin
    after_byte = state_i;
    if (beat_i.empty_string) begin
      after_byte.phase = PhReject;
    end else begin
      case (state_i.phase)
        PhStart: begin
          if (beat_i.char_byte == CharZero) begin
            after_byte.phase = PhZero;
          end else if (beat_i.char_byte == CharMinus) begin
            after_byte.minus_seen = 1'b1;
            after_byte.phase      = PhMinus;
          end else if (is_digit) begin
            after_byte.magnitude = {60'd0, digit};
            after_byte.phase     = PhDigits;
          end else begin
            after_byte.phase = PhReject;
          end
        end
        PhMinus: begin
          if (is_digit && digit != 4'd0) begin
            after_byte.magnitude = {60'd0, digit};
            after_byte.phase     = PhDigits;
          end else begin
            after_byte.phase = PhReject;
          end
        end
        PhDigits: begin
          if (!is_digit || state_i.magnitude > MagDiv10Limit || sum_wide[64]) begin
            after_byte.phase = PhReject;
          end else begin
            after_byte.magnitude = sum_wide[63:0];
          end
        end
        default: begin
          after_byte.phase = PhReject;
        end
      endcase
    end
  end

  always_comb begin
    result_o.parse_ok     = 1'b0;
    result_o.parsed_value = '0;
    if (after_byte.phase == PhZero) begin
      result_o.parse_ok = 1'b1;
    end else if (after_byte.phase == PhDigits) begin
      if (after_byte.minus_seen) begin
        if (after_byte.magnitude <= NegLimit) begin
          result_o.parse_ok     = 1'b1;
          result_o.parsed_value = $signed(64'd0 - after_byte.magnitude);
        end
      end else if (after_byte.magnitude <= PosLimit) begin
        result_o.parse_ok     = 1'b1;
        result_o.parsed_value = $signed(after_byte.magnitude);
      end
    end
  end

  // The last beat of a string returns the parser to the start of a new one.
  always_comb begin
    state_o = after_byte;
    if (beat_i.is_last) begin
      state_o.magnitude  = '0;
      state_o.minus_seen = 1'b0;
      state_o.phase      = PhStart;
    end
  end

endmodule

// File: hdl/strict_decimal_text_to_int64_top.sv
// Strict decimal text to signed 64-bit integer parser, top level.
// Depends on sdt2i_pkg and sdt2i_digit_step.
//
// The block takes one ASCII character per beat and gives one result beat on the beat
// marked is_last: parse_ok and the two's complement value, which is 0 when rejected.
// A character beat is registered, then folded into the parse state from that register
// by one multiply-by-ten shift-add and compare, so one character is taken every cycle
// unless the input stalls. A result beat is registered when its last character is folded. The output
// register lets the next string flow in while a result waits; input stalls only
// when a last character is pending and the previous result has not been taken.
module strict_decimal_text_to_int64_top
  import sdt2i_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic         in_valid_q;
  in_beat_t     in_q;
  parse_state_t state_q;
  parse_state_t state_d;
  out_beat_t    result;
  logic         out_valid_q;
  logic         out_valid_d;
  out_beat_t    out_q;
  logic         advance;
  logic         emit;

  sdt2i_digit_step u_digit_step (
    .state_i  (state_q),
    .beat_i   (in_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // A held character moves on unless it is a last beat blocked by a waiting result.
  assign advance    = in_valid_q && (!in_q.is_last || !out_valid_q || out_ready_i);
  assign emit       = advance && in_q.is_last;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      state_q.magnitude  <= '0;
      state_q.minus_seen <= 1'b0;
      state_q.phase      <= PhStart;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_reject_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.parse_ok |-> out_data_o.parsed_value == 64'sd0)
    else $error("rejected result carries a nonzero value");

  a_last_clears_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> state_q.phase == PhStart && state_q.magnitude == 64'd0 && !state_q.minus_seen)
    else $error("parse state not cleared after the last beat of a string");

  a_stall_only_on_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && in_q.is_last && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked last beat");

  a_emit_loads_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o)
    else $error("last beat processed without a result beat");
`endif

endmodule

// File: tb/sv/sdt2i_parse_checker.sv
// Checker for the strict decimal text to int64 parser: watches both beat channels,
// folds every accepted character into its own parse state and compares result beats.
// Depends on sdt2i_pkg.
`timescale 1ns / 1ps

module sdt2i_parse_checker
  import sdt2i_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_beat_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic [63:0] mag_acc;
  logic        neg_sign;
  phase_e      phase;
  out_beat_t   expected_parses[$];
  int          mismatches;

  task automatic fold_char(input in_beat_t beat);
    logic        is_digit;
    logic [63:0] digit;
    logic [63:0] times_ten;
    out_beat_t   parse;
    is_digit = (beat.char_byte >= CharZero) && (beat.char_byte <= CharNine);
    digit    = is_digit ? 64'(beat.char_byte - CharZero) : 64'd0;
    if (beat.empty_string) begin
      phase = PhReject;
    end else begin
      case (phase)
        PhStart: begin
          if (beat.char_byte == CharZero) begin
            phase = PhZero;
          end else if (beat.char_byte == CharMinus) begin
            neg_sign = 1'b1;
            phase    = PhMinus;
          end else if (is_digit) begin
            mag_acc = digit;
            phase   = PhDigits;
          end else begin
            phase = PhReject;
          end
        end
        PhMinus: begin
          if (is_digit && digit != 64'd0) begin
            mag_acc = digit;
            phase   = PhDigits;
          end else begin
            phase = PhReject;
          end
        end
        PhDigits: begin
          if (!is_digit || mag_acc > MagDiv10Limit) begin
            phase = PhReject;
          end else begin
            times_ten = mag_acc * 64'd10;
            // The add of the digit may still carry out of 64 bits.
            if (times_ten > ~64'd0 - digit) phase = PhReject;
            else mag_acc = times_ten + digit;
          end
        end
        default: phase = PhReject;
      endcase
    end
    if (beat.is_last) begin
      parse.parse_ok     = 1'b0;
      parse.parsed_value = '0;
      if (phase == PhZero) begin
        parse.parse_ok = 1'b1;
      end else if (phase == PhDigits) begin
        if (neg_sign && mag_acc <= NegLimit) begin
          parse.parse_ok     = 1'b1;
          parse.parsed_value = 64'd0 - mag_acc;
        end else if (!neg_sign && mag_acc <= PosLimit) begin
          parse.parse_ok     = 1'b1;
          parse.parsed_value = mag_acc;
        end
      end
      expected_parses.push_back(parse);
      mag_acc  = '0;
      neg_sign = 1'b0;
      phase    = PhStart;
    end
  endtask

  task automatic compare_result(input out_beat_t got);
    out_beat_t want;
    if (expected_parses.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with no string pending: expected none, actual ok=%0b value=%0d",
               $time, got.parse_ok, got.parsed_value);
    end else begin
      want = expected_parses.pop_front();
      if (got.parse_ok !== want.parse_ok) begin
        mismatches++;
        $display("%0t: parse_ok mismatch: expected %0b, actual %0b",
                 $time, want.parse_ok, got.parse_ok);
      end
      if (got.parsed_value !== want.parsed_value) begin
        mismatches++;
        $display("%0t: parsed_value mismatch: expected %0d, actual %0d",
                 $time, want.parsed_value, got.parsed_value);
      end
    end
  endtask

  // A result beat can never belong to a character taken on the same edge,
  // so the compare runs before the fold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_acc    = '0;
      neg_sign   = 1'b0;
      phase      = PhStart;
      mismatches = 0;
      expected_parses.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) compare_result(out_data_i);
      if (in_valid_i && in_ready_i) fold_char(in_data_i);
      fail_count_o <= mismatches;
      pending_o    <= expected_parses.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the strict decimal text to int64 parser: clock, reset, string
// stimulus under several idle and stall mixes, watchdog and verdict.
// Depends on sdt2i_pkg, strict_decimal_text_to_int64_top and sdt2i_parse_checker.
`timescale 1ns / 1ps

module tb;
  import sdt2i_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int TailCycles = 8;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  int        mismatch_count;
  int        parses_pending;
  int        idle_pct;
  int        stall_pct;
  int        sent_beats;
  int        quiet_cycles;
  in_beat_t  text_q[$];

  always #6 clk = ~clk;

  strict_decimal_text_to_int64_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  sdt2i_parse_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(mismatch_count),
    .pending_o   (parses_pending)
  );

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_char(input logic [7:0] c, input logic empty = 1'b0);
    text_q.push_back({c, 1'b0, empty});
  endtask

  task automatic push_digit(input int lo);
    push_char(8'(CharZero + $urandom_range(9, lo)));
  endtask

  task automatic push_short_number();
    int n;
    if ($urandom_range(1)) push_char(CharMinus);
    push_digit(1);
    n = $urandom_range(5);
    repeat (n) push_digit(0);
  endtask

  task automatic drive_beat(input in_beat_t beat);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text();
    text_q[text_q.size() - 1].is_last = 1'b1;
    foreach (text_q[i]) drive_beat(text_q[i]);
    sent_beats += text_q.size();
    text_q.delete();
  endtask

  // Sender holds off until every string sent so far has its result back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (parses_pending != 0) @(posedge clk);
  endtask

  task automatic make_random_text();
    int          kind;
    int          n;
    int          pos;
    int          pick;
    logic [79:0] mag;
    logic [7:0]  digits[$];
    kind = $urandom_range(99);
    if (kind < 30) begin
      push_short_number();
    end else if (kind < 45) begin
      // Values around the signed limits and the unsigned wrap point.
      pick = $urandom_range(3);
      case (pick)
        0:       mag = 80'(PosLimit);
        1:       mag = 80'(NegLimit);
        2:       mag = 80'(MagDiv10Limit);
        default: mag = 80'(64'hFFFF_FFFF_FFFF_FFFF);
      endcase
      mag = mag + $urandom_range(15) - 3;
      if ($urandom_range(1)) push_char(CharMinus);
      do begin
        digits.push_front(8'(CharZero + mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      foreach (digits[i]) push_char(digits[i]);
      if (pick == 2) push_digit(0);
    end else if (kind < 55) begin
      if ($urandom_range(1)) push_char(CharMinus);
      push_digit(1);
      n = $urandom_range(22, 17);
      repeat (n) push_digit(0);
    end else if (kind < 63) begin
      case ($urandom_range(3))
        0: push_char(CharZero);
        1: push_char(CharMinus);
        2: begin
          push_char(CharMinus);
          push_char(CharZero);
          n = $urandom_range(2);
          repeat (n) push_digit(0);
        end
        default: begin
          push_char(CharZero);
          n = $urandom_range(3, 1);
          repeat (n) push_digit(0);
        end
      endcase
    end else if (kind < 75) begin
      push_short_number();
      pos = $urandom_range(text_q.size() - 1);
      text_q[pos].char_byte = 8'($urandom_range(255));
    end else if (kind < 85) begin
      if ($urandom_range(1)) begin
        push_char(8'($urandom_range(255)), 1'b1);
      end else begin
        push_short_number();
        pos = $urandom_range(text_q.size() - 1);
        text_q[pos].char_byte    = 8'($urandom_range(255));
        text_q[pos].empty_string = 1'b1;
      end
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        case ($urandom_range(4))
          0:       push_char(CharMinus);
          1:       push_char(CharZero - 8'd1);
          2:       push_char(CharNine + 8'd1);
          3:       push_digit(0);
          default: push_char(8'($urandom_range(255)));
        endcase
      end
    end
    send_text();
  endtask

  initial begin
    int idle_plan[4]  = '{0, 86, 0, 25};
    int stall_plan[4] = '{0, 0, 86, 25};
    int beat_goal[4]  = '{300, 600, 900, 1150};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    sent_beats = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lone zero, empty string, lone minus, minus zero, leading zero, lone nine, minus eight.
    push_char(CharZero);                                 send_text();
    push_char(8'hFF, 1'b1);                              send_text();
    push_char(CharMinus);                                send_text();
    push_char(CharMinus); push_char(CharZero);           send_text();
    push_char(CharZero);  push_char(8'(CharZero + 5));   send_text();
    push_char(CharNine);                                 send_text();
    push_char(CharMinus); push_char(8'(CharZero + 8));   send_text();
    // Characters just outside the digit range and the byte extremes.
    push_char(CharZero - 8'd1);                          send_text();
    push_char(CharNine + 8'd1);                          send_text();
    push_char(8'hFF);                                    send_text();
    push_char(8'h00);                                    send_text();
    // Empty flag on a non-final beat with a byte after it, then a trailing non-digit byte.
    push_char(8'(CharZero + 1)); push_char(8'h00, 1'b1);
    push_char(8'(CharZero + 2));                         send_text();
    push_char(8'(CharZero + 1)); push_char(8'(CharZero + 2));
    push_char(8'h61);                                    send_text();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      while (sent_beats < beat_goal[p]) make_random_text();
      if (p == 0) drain_results();
    end

    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && parses_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
